[rtl/chbh_pkg.sv]
`timescale 1ns / 1ps
package chbh_pkg;

  localparam int unsigned KEY_W   = 8;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned DIV_STEPS = ACC_W;
  localparam int unsigned CNT_W   = $clog2(DIV_STEPS);

  // acc * 31 == (acc << 5) - acc
  localparam int unsigned HASH_SHIFT = 5;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(1021);
  localparam logic [CNT_W-1:0]  CNT_LAST         = CNT_W'(DIV_STEPS - 1);

  localparam logic [KEY_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [KEY_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [KEY_W-1:0] ASCII_CASE    = 8'h20;
  localparam logic [KEY_W-1:0] KEY_END       = 8'h00;

  typedef struct packed {
    logic absorb;
    logic last;
    logic step;
    logic load_out;
  } chbh_cmd_t;

  function automatic logic [KEY_W-1:0] fold_case(input logic [KEY_W-1:0] b);
    if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
      return b + ASCII_CASE;
    end
    return b;
  endfunction

endpackage

[rtl/case_folding_string_bucket_hash.sv]
`timescale 1ns / 1ps
// Case-folding base-31 string hash, reduced to a bucket index.
// Input stream: one key byte per request, tlast on the final byte of a key.
// A zero byte ends the key; further bytes up to tlast are taken and ignored.
// Capitals A..Z are folded to lower case before hashing.
// Output stream: one bucket index per key, hash modulo the table size
// (0 when the table size is 0).
// cfg_we/cfg_wdata write the table size (reset value 1021); write while idle.
// Throughput: one byte per cycle while a key is absorbed. After the tlast byte
// the input stalls while the remainder unit takes one dividend bit per cycle
// (bar the stall on the last step below), then loads the index.
// The result sits in an output register, so the next key is absorbed while
// it waits; if the receiver still holds the previous result when the next
// remainder completes, the block stalls on its last step until it is taken.
// Reset is synchronous, active low: control and hash state cleared, no result pending.
module case_folding_string_bucket_hash
  import chbh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [KEY_W-1:0]  in_tdata,   // [7:0] key_byte
  input  logic              in_tlast,   // last
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [SIZE_W-1:0] out_tdata,  // [31:0] bucket_index
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  chbh_cmd_t cmd;

  chbh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  chbh_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .key_byte     (in_tdata),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .bucket_index (out_tdata)
  );

endmodule

[rtl/chbh_ctrl.sv]
`timescale 1ns / 1ps
module chbh_ctrl
  import chbh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tlast,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output chbh_cmd_t  cmd
);

  typedef enum logic {
    S_ABSORB,
    S_DIVIDE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             accept;

  assign in_tready  = (state_r == S_ABSORB);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd.absorb    = 1'b0;
    cmd.last      = 1'b0;
    cmd.step      = 1'b0;
    cmd.load_out  = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;
    case (state_r)
      S_ABSORB: begin
        cmd.absorb = accept;
        if (accept && in_tlast) begin
          cmd.last  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (cnt_r != CNT_LAST) begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end else if (out_free) begin
          cmd.step      = 1'b1;
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ABSORB;
        end
      end
      default: begin
        state_nxt = S_ABSORB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ABSORB;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/chbh_dpath.sv]
`timescale 1ns / 1ps
module chbh_dpath
  import chbh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [KEY_W-1:0]  key_byte,
  input  chbh_cmd_t         cmd,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  output logic [SIZE_W-1:0] bucket_index
);

  logic [SIZE_W-1:0] size_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt, acc_hash;
  logic              term_r, term_nxt;
  logic [ACC_W-1:0]  dvd_r;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W-1:0] out_r;

  assign acc_hash = (acc_r << HASH_SHIFT) - acc_r + ACC_W'(fold_case(key_byte));

  always_comb begin
    acc_nxt  = acc_r;
    term_nxt = term_r;
    if (!term_r) begin
      if (key_byte == KEY_END) begin
        term_nxt = 1'b1;
      end else begin
        acc_nxt = acc_hash;
      end
    end
  end

  // restoring remainder, one dividend bit per step
  assign trial   = {rem_r, dvd_r[ACC_W-1]};
  assign rem_nxt = (trial >= {1'b0, size_r}) ? SIZE_W'(trial - {1'b0, size_r})
                                             : trial[SIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= TABLE_SIZE_RESET;
      acc_r  <= '0;
      term_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (cmd.last) begin
        acc_r  <= '0;
        term_r <= 1'b0;
      end else if (cmd.absorb) begin
        acc_r  <= acc_nxt;
        term_r <= term_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.last) begin
      dvd_r <= acc_nxt;
      rem_r <= '0;
    end else if (cmd.step) begin
      dvd_r <= {dvd_r[ACC_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
    if (cmd.load_out) begin
      out_r <= (size_r == '0) ? '0 : rem_nxt;
    end
  end

  assign bucket_index = out_r;

endmodule
